### rtl/core/rcmp_pkg.sv
`timescale 1ns / 1ps

package rcmp_pkg;

    localparam int LEN_W = 11;
    localparam int CNT_W = 11;
    localparam int NUM_PIECES = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PIECE_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIECE_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIECE_C = 2'd2;

    localparam logic [LEN_W-1:0] PIECE_RESET = 11'd1;

    typedef struct packed {
        logic             reach;
        logic [CNT_W-1:0] count;
    } entry_t;

    localparam entry_t EMPTY_ENTRY = '{reach: 1'b0, count: '0};
    localparam entry_t ORIGIN_ENTRY = '{reach: 1'b1, count: '0};

    typedef struct packed {
        logic usable;
        logic fwd;
    } tap_ctl_t;

endpackage

### rtl/core/rcmp_table.sv
`timescale 1ns / 1ps

module rcmp_table #(
    parameter int DEPTH = 1025,
    parameter int AW = 11
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  rcmp_pkg::entry_t    wdata,
    input  logic [AW-1:0]       raddr [rcmp_pkg::NUM_PIECES],
    output rcmp_pkg::entry_t    rdata [rcmp_pkg::NUM_PIECES]
);

    // Two copies of the table: the first serves two read ports, the second one.
    rcmp_pkg::entry_t mem_ab [DEPTH];
    rcmp_pkg::entry_t mem_c [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_ab[waddr] <= wdata;
            mem_c[waddr] <= wdata;
        end
        rdata[0] <= mem_ab[raddr[0]];
        rdata[1] <= mem_ab[raddr[1]];
        rdata[2] <= mem_c[raddr[2]];
    end

endmodule

### rtl/core/rcmp_best.sv
`timescale 1ns / 1ps

module rcmp_best (
    input  rcmp_pkg::entry_t    rdata [rcmp_pkg::NUM_PIECES],
    input  rcmp_pkg::tap_ctl_t  tap [rcmp_pkg::NUM_PIECES],
    input  rcmp_pkg::entry_t    fwd_val,
    output rcmp_pkg::entry_t    best
);

    rcmp_pkg::entry_t                src [rcmp_pkg::NUM_PIECES];
    logic [rcmp_pkg::NUM_PIECES-1:0] ok;
    logic [rcmp_pkg::CNT_W-1:0]      cand [rcmp_pkg::NUM_PIECES];

    always_comb
    begin
        for (int p = 0; p < rcmp_pkg::NUM_PIECES; p++)
        begin
            src[p] = tap[p].fwd ? fwd_val : rdata[p];
            ok[p] = tap[p].usable & src[p].reach;
            cand[p] = src[p].count + rcmp_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        best = rcmp_pkg::EMPTY_ENTRY;
        for (int p = 0; p < rcmp_pkg::NUM_PIECES; p++)
        begin
            if (ok[p] && (!best.reach || cand[p] > best.count))
            begin
                best.reach = 1'b1;
                best.count = cand[p];
            end
        end
    end

endmodule

### rtl/core/ribbon_cut_max_pieces_core.sv
// Answers, for each ribbon length, the largest number of pieces into which it can be cut with
// nothing left over, every piece being one of the three configured lengths (a length of zero
// disables that piece). A transaction of length n is offered as a result once the table holds
// entry n: the table is rebuilt from entry 0 upward at one entry per cycle, set by the single
// write port of the table memory, with the three back-references read through registered
// memory ports and the most recent entry forwarded. A length of zero, and lengths above
// MAX_LENGTH (answered as not possible), skip the table rebuild and go to the finishing state. One
// transaction is worked on at a time; the input side reopens in the cycle the result is offered,
// and a result still waiting at the output holds back the next one until it is taken.
`timescale 1ns / 1ps

module ribbon_cut_max_pieces_core #(
    parameter int MAX_LENGTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rcmp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rcmp_pkg::LEN_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rcmp_pkg::LEN_W-1:0]        ribbon_length,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rcmp_pkg::CNT_W-1:0]        pieces,
    output logic                              possible
);

    localparam int DEPTH = MAX_LENGTH + 1;
    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = (AW > rcmp_pkg::LEN_W) ? AW : rcmp_pkg::LEN_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_LENGTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t                      state_reg;
    logic [rcmp_pkg::LEN_W-1:0]  piece_reg [rcmp_pkg::NUM_PIECES];
    logic [CW-1:0]               n_reg;
    logic [CW-1:0]               issue_idx_reg;
    logic                        issue_on_reg;
    logic                        s2_on_reg;
    logic [CW-1:0]               s2_idx_reg;
    rcmp_pkg::tap_ctl_t          tap_reg [rcmp_pkg::NUM_PIECES];
    rcmp_pkg::entry_t            last_val_reg;
    rcmp_pkg::entry_t            res_reg;
    logic                        out_valid_reg;
    logic [rcmp_pkg::CNT_W-1:0]  pieces_reg;
    logic                        possible_reg;

    logic                        in_acc;
    logic [CW-1:0]               len_in;
    logic                        we;
    logic [AW-1:0]               waddr;
    rcmp_pkg::entry_t            wdata;
    logic [AW-1:0]               raddr [rcmp_pkg::NUM_PIECES];
    rcmp_pkg::entry_t            rdata [rcmp_pkg::NUM_PIECES];
    rcmp_pkg::tap_ctl_t          tap_now [rcmp_pkg::NUM_PIECES];
    rcmp_pkg::entry_t            best_val;
    logic [CW-1:0]               plen [rcmp_pkg::NUM_PIECES];

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc = in_valid & in_ready;
    assign len_in = CW'(ribbon_length);
    assign out_valid = out_valid_reg;
    assign pieces = pieces_reg;
    assign possible = possible_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < rcmp_pkg::NUM_PIECES; p++)
            begin
                piece_reg[p] <= rcmp_pkg::PIECE_RESET;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rcmp_pkg::REG_PIECE_A: piece_reg[0] <= cfg_data;
                rcmp_pkg::REG_PIECE_B: piece_reg[1] <= cfg_data;
                rcmp_pkg::REG_PIECE_C: piece_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign we = (in_acc && len_in <= MAX_C) || (state_reg == ST_RUN && s2_on_reg);
    assign waddr = (state_reg == ST_IDLE) ? '0 : AW'(s2_idx_reg);
    assign wdata = (state_reg == ST_IDLE) ? rcmp_pkg::ORIGIN_ENTRY : best_val;

    always_comb
    begin
        for (int p = 0; p < rcmp_pkg::NUM_PIECES; p++)
        begin
            plen[p] = CW'(piece_reg[p]);
            tap_now[p].usable = (plen[p] != '0) && (plen[p] <= issue_idx_reg);
            raddr[p] = tap_now[p].usable ? AW'(issue_idx_reg - plen[p]) : '0;
            tap_now[p].fwd = tap_now[p].usable && we && (raddr[p] == waddr);
        end
    end

    rcmp_table #(
        .DEPTH(DEPTH),
        .AW(AW)
    ) u_table (
        .clk(clk),
        .we(we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    rcmp_best u_best (
        .rdata(rdata),
        .tap(tap_reg),
        .fwd_val(last_val_reg),
        .best(best_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            issue_on_reg <= 1'b0;
            s2_on_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != ST_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        n_reg <= len_in;
                        last_val_reg <= rcmp_pkg::ORIGIN_ENTRY;
                        s2_on_reg <= 1'b0;
                        if (len_in > MAX_C)
                        begin
                            res_reg <= rcmp_pkg::EMPTY_ENTRY;
                            state_reg <= ST_FINISH;
                        end
                        else if (len_in == '0)
                        begin
                            res_reg <= rcmp_pkg::ORIGIN_ENTRY;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            issue_idx_reg <= CW'(1);
                            issue_on_reg <= 1'b1;
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    s2_on_reg <= issue_on_reg;
                    s2_idx_reg <= issue_idx_reg;
                    tap_reg <= tap_now;
                    if (issue_on_reg)
                    begin
                        if (issue_idx_reg == n_reg)
                        begin
                            issue_on_reg <= 1'b0;
                        end
                        else
                        begin
                            issue_idx_reg <= issue_idx_reg + CW'(1);
                        end
                    end
                    if (s2_on_reg)
                    begin
                        last_val_reg <= best_val;
                        if (s2_idx_reg == n_reg)
                        begin
                            res_reg <= best_val;
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        pieces_reg <= res_reg.reach ? res_reg.count : '0;
                        possible_reg <= res_reg.reach;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/rcmp_checker.sv
`timescale 1ns / 1ps

module rcmp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [rcmp_pkg::CNT_W-1:0]        pieces,
    input logic                              possible
);

    // A result that is not possible always carries a zero count.
    a_zero_when_impossible: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !possible |-> pieces == '0)
        else $error("count not zero on an impossible result");

    // Only one transaction is worked on at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted again straight after a transaction");

    // The input side reopens only once a result has been produced.
    a_result_before_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready ##1 in_ready |-> out_valid)
        else $error("input side reopened without a result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pieces) && $stable(possible))
        else $error("result changed while stalled");

endmodule

bind ribbon_cut_max_pieces_core rcmp_checker u_rcmp_checker (.*);

### dv/tb_ribbon_cut_max_pieces_core.sv
`timescale 1ns / 1ps

module tb_ribbon_cut_max_pieces_core;

    localparam int MAX_LEN = 1024;
    localparam logic [rcmp_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 48;

    typedef struct packed {
        logic [rcmp_pkg::CNT_W-1:0] pieces;
        logic                       possible;
    } cut_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [rcmp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rcmp_pkg::LEN_W-1:0]     cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [rcmp_pkg::LEN_W-1:0]     ribbon_length;
    logic                           out_valid;
    logic                           out_ready;
    logic [rcmp_pkg::CNT_W-1:0]     pieces;
    logic                           possible;

    logic                           idle_on;
    logic                           stall_on;
    int                             mismatch_count = 0;

    cut_result_t                    cut_expect_q[$];
    logic [rcmp_pkg::LEN_W-1:0]     piece_len [rcmp_pkg::NUM_PIECES];
    rcmp_pkg::entry_t               cut_table [0:MAX_LEN];

    ribbon_cut_max_pieces_core #(
        .MAX_LENGTH(MAX_LEN)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ribbon_length(ribbon_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pieces       (pieces),
        .possible     (possible)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= !(stall_on && $urandom_range(0, 99) < 25);
    end

    // Rebuilds the table from entry 0 up to the requested length, as the block does.
    function automatic cut_result_t predict_cut(input logic [rcmp_pkg::LEN_W-1:0] len);
        cut_result_t                res;
        logic [rcmp_pkg::CNT_W-1:0] cand;
        int                         pos;
        int                         k;
        res = '{pieces: '0, possible: 1'b0};
        if (len > MAX_LEN)
        begin
            return res;
        end
        cut_table[0] = rcmp_pkg::ORIGIN_ENTRY;
        for (pos = 1; pos <= len; pos++)
        begin
            cut_table[pos] = rcmp_pkg::EMPTY_ENTRY;
            for (k = 0; k < rcmp_pkg::NUM_PIECES; k++)
            begin
                if (piece_len[k] != 0 && piece_len[k] <= pos
                    && cut_table[pos - piece_len[k]].reach)
                begin
                    cand = cut_table[pos - piece_len[k]].count + 1'b1;
                    if (!cut_table[pos].reach || cand > cut_table[pos].count)
                    begin
                        cut_table[pos] = '{reach: 1'b1, count: cand};
                    end
                end
            end
        end
        if (cut_table[len].reach)
        begin
            res = '{pieces: cut_table[len].count, possible: 1'b1};
        end
        return res;
    endfunction

    function automatic logic [rcmp_pkg::LEN_W-1:0] pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return rcmp_pkg::LEN_W'($urandom_range(0, 40));
        else if (roll < 90)
            return rcmp_pkg::LEN_W'($urandom_range(41, 300));
        else if (roll < 97)
            return rcmp_pkg::LEN_W'($urandom_range(301, MAX_LEN));
        else
            return rcmp_pkg::LEN_W'($urandom_range(MAX_LEN + 1, 2047));
    endfunction

    function automatic logic [rcmp_pkg::LEN_W-1:0] pick_piece();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        else if (roll < 80)
            return rcmp_pkg::LEN_W'($urandom_range(1, 12));
        else if (roll < 92)
            return rcmp_pkg::LEN_W'($urandom_range(13, 100));
        else
            return rcmp_pkg::LEN_W'($urandom_range(0, 2047));
    endfunction

    task automatic send_length(input logic [rcmp_pkg::LEN_W-1:0] len);
        if (idle_on && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        ribbon_length <= len;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        cut_expect_q.push_back(predict_cut(len));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (cut_expect_q.size() != 0);
    endtask

    // A write to the spare index follows each set of piece lengths and must change nothing.
    task automatic program_pieces(input logic [rcmp_pkg::LEN_W-1:0] a, b, c);
        logic [rcmp_pkg::CFG_IDX_W-1:0] idx [4];
        logic [rcmp_pkg::LEN_W-1:0]     val [4];
        int                             k;
        wait_drained();
        idx = '{rcmp_pkg::REG_PIECE_A, rcmp_pkg::REG_PIECE_B, rcmp_pkg::REG_PIECE_C,
                REG_SPARE};
        val = '{a, b, c, rcmp_pkg::LEN_W'($urandom_range(0, 2047))};
        for (k = 0; k < 4; k++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            @(posedge clk);
            if (idx[k] != REG_SPARE)
            begin
                piece_len[idx[k]] = val[k];
            end
        end
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_pieces();
        logic [rcmp_pkg::LEN_W-1:0] lens [7];
        lens = '{11'd0, 11'd1, 11'd2, 11'd1023, 11'd1024, 11'd1025, 11'd2047};
        foreach (lens[i])
        begin
            send_length(lens[i]);
        end
    endtask

    task automatic test_special_pieces();
        program_pieces(11'd0, 11'd0, 11'd0);
        send_length(11'd0);
        send_length(11'd1);
        send_length(11'd1024);
        program_pieces(11'd0, 11'd0, 11'd4);
        send_length(11'd8);
        send_length(11'd6);
        program_pieces(11'd2047, 11'd1024, 11'd3);
        send_length(11'd10);
        send_length(11'd2);
        send_length(11'd1023);
        send_length(11'd1024);
        program_pieces(11'd1024, 11'd1024, 11'd1024);
        send_length(11'd1024);
        send_length(11'd1023);
        program_pieces(11'd2, 11'd3, 11'd5);
        send_length(11'd1);
        send_length(11'd7);
        send_length(11'd1024);
    endtask

    task automatic test_random_queries();
        int phase;
        int n;
        for (phase = 0; phase < PHASES; phase++)
        begin
            program_pieces(pick_piece(), pick_piece(), pick_piece());
            idle_on = (phase != 3);
            stall_on = (phase != 3);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    wait_drained();
                end
                send_length(pick_length());
            end
        end
        idle_on = 1'b1;
        stall_on = 1'b1;
    endtask

    always @(posedge clk)
    begin : result_check
        cut_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (cut_expect_q.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("Unexpected transaction: pieces %0d possible %0b",
                             pieces, possible);
                mismatch_count++;
            end
            else
            begin
                want = cut_expect_q.pop_front();
                if (pieces !== want.pieces || possible !== want.possible)
                begin
                    if (mismatch_count < 10)
                        $display("Mismatch: expected pieces %0d possible %0b, got %0d %0b",
                                 want.pieces, want.possible, pieces, possible);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        idle_on = 1'b1;
        stall_on = 1'b1;
        piece_len = '{rcmp_pkg::PIECE_RESET, rcmp_pkg::PIECE_RESET, rcmp_pkg::PIECE_RESET};
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        ribbon_length <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_pieces();
        test_special_pieces();
        test_random_queries();

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && cut_expect_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### ribbon_cut_max_pieces_core.f
rtl/core/rcmp_pkg.sv
rtl/core/rcmp_table.sv
rtl/core/rcmp_best.sv
rtl/core/ribbon_cut_max_pieces_core.sv
rtl/core/rcmp_checker.sv
dv/tb_ribbon_cut_max_pieces_core.sv
